FILE: hw/rtl/obd_pkg.sv
package obd_pkg;

  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [2:0] STAT_SENT      = 3'd0;
  localparam logic [2:0] STAT_BUSY      = 3'd1;
  localparam logic [2:0] STAT_SEND_FAIL = 3'd2;
  localparam logic [2:0] STAT_MATCHED   = 3'd3;
  localparam logic [2:0] STAT_IGNORED   = 3'd4;
  localparam logic [2:0] STAT_TIMED_OUT = 3'd5;
  localparam logic [2:0] STAT_IDLE_TICK = 3'd6;

  localparam logic [1:0] CFG_REQUEST_ID    = 2'd0;
  localparam logic [1:0] CFG_RESPONSE_BASE = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [10:0] REQUEST_ID_RST    = 11'd2015;
  localparam logic [10:0] RESPONSE_BASE_RST = 11'd2024;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam logic [7:0]  REQ_LEN_BYTE = 8'h02;
  localparam logic [7:0]  PAD_BYTE     = 8'hCC;
  localparam logic [8:0]  RSP_MODE_OFS = 9'h040;
  localparam logic [11:0] ID_SPAN      = 12'd7;
  localparam logic [3:0]  MIN_RSP_LEN  = 4'd3;
  localparam logic [7:0]  RSP_HDR_LEN  = 8'd2;
  localparam logic [2:0]  MAX_DATA     = 3'd5;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic       match;
    logic [2:0] count;
  } rsp_chk_t;

endpackage

FILE: hw/rtl/obd_cfg_if.sv
interface obd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/obd_req_if.sv
interface obd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  mode;
  logic [7:0]  pid;
  logic        with_callback;
  logic        send_ok;
  logic [10:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;

  modport source (output valid, output action, output mode, output pid, output with_callback,
                  output send_ok, output frame_id, output frame_len, output frame_data,
                  input ready);
  modport sink (input valid, input action, input mode, input pid, input with_callback,
                input send_ok, input frame_id, input frame_len, input frame_data,
                output ready);
endinterface

FILE: hw/rtl/obd_res_if.sv
interface obd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        tx_valid;
  logic [10:0] tx_id;
  logic [63:0] tx_data;
  logic        deliver;
  logic [2:0]  data_count;
  logic [39:0] data_bytes;

  modport source (output valid, output status, output tx_valid, output tx_id, output tx_data,
                  output deliver, output data_count, output data_bytes, input ready);
  modport sink (input valid, input status, input tx_valid, input tx_id, input tx_data,
                input deliver, input data_count, input data_bytes, output ready);
endinterface

FILE: hw/rtl/obd_rsp_check.sv
module obd_rsp_check (
  input  logic [10:0]      frame_id,
  input  logic [3:0]       frame_len,
  input  logic [23:0]      frame_head,
  input  logic [10:0]      response_base,
  input  logic             waiting,
  input  logic [7:0]       pending_mode,
  input  logic [7:0]       pending_pid,
  output obd_pkg::rsp_chk_t chk
);

  logic [11:0] id_hi;
  logic        id_ok;
  logic [8:0]  mode_exp;
  logic [7:0]  cnt_raw;

  assign id_hi    = {1'b0, response_base} + obd_pkg::ID_SPAN;
  assign id_ok    = (frame_id >= response_base) && ({1'b0, frame_id} <= id_hi);
  assign mode_exp = {1'b0, pending_mode} + obd_pkg::RSP_MODE_OFS;
  assign cnt_raw  = frame_head[7:0] - obd_pkg::RSP_HDR_LEN;

  always_comb begin
    chk.match = id_ok && waiting && (frame_len >= obd_pkg::MIN_RSP_LEN) &&
                ({1'b0, frame_head[15:8]} == mode_exp) && (frame_head[23:16] == pending_pid);
    if (cnt_raw > {5'd0, obd_pkg::MAX_DATA}) begin
      chk.count = obd_pkg::MAX_DATA;
    end else begin
      chk.count = cnt_raw[2:0];
    end
  end

endmodule

FILE: hw/rtl/obd_pid_request_tracker.sv
// The result of an input transfer is registered in the output register.
// Throughput: one item per cycle unless stalled; each is decided in the cycle taken.
// Input ready follows the output register (free or being drained this cycle).
// Reset (rst, synchronous, active high) restores the register defaults, drops any
// outstanding request, clears the elapsed count and clears all 256 callback marks.
module obd_pid_request_tracker (
  input  logic      clk,
  input  logic      rst,
  obd_cfg_if.sink   cfg,
  obd_req_if.sink   req,
  obd_res_if.source res
);

  logic [10:0]  request_id;
  logic [10:0]  response_base;
  logic [15:0]  timeout_ticks;

  logic         waiting, waiting_next;
  logic [7:0]   pending_mode, pending_mode_next;
  logic [7:0]   pending_pid, pending_pid_next;
  logic         pending_marked, pending_marked_next;
  logic [16:0]  elapsed, elapsed_next;
  logic [255:0] cb_map;
  logic         mark_set;

  logic         out_valid;
  logic [2:0]   status, status_next;
  logic         tx_valid, tx_valid_next;
  logic [10:0]  tx_id, tx_id_next;
  logic [63:0]  tx_data, tx_data_next;
  logic         deliver, deliver_next;
  logic [2:0]   data_count, data_count_next;
  logic [39:0]  data_bytes, data_bytes_next;

  logic         accept;
  logic [16:0]  elapsed_inc;
  obd_pkg::rsp_chk_t chk;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign res.valid      = out_valid;
  assign res.status     = status;
  assign res.tx_valid   = tx_valid;
  assign res.tx_id      = tx_id;
  assign res.tx_data    = tx_data;
  assign res.deliver    = deliver;
  assign res.data_count = data_count;
  assign res.data_bytes = data_bytes;

  obd_rsp_check u_rsp_check (
    .frame_id      (req.frame_id),
    .frame_len     (req.frame_len),
    .frame_head    (req.frame_data[23:0]),
    .response_base (response_base),
    .waiting       (waiting),
    .pending_mode  (pending_mode),
    .pending_pid   (pending_pid),
    .chk           (chk)
  );

  assign elapsed_inc = (elapsed == obd_pkg::ELAPSED_MAX) ? elapsed : elapsed + 17'd1;

  always_comb begin
    waiting_next        = waiting;
    pending_mode_next   = pending_mode;
    pending_pid_next    = pending_pid;
    pending_marked_next = pending_marked;
    elapsed_next        = elapsed;
    mark_set            = 1'b0;
    status_next         = obd_pkg::STAT_IDLE_TICK;
    tx_valid_next       = 1'b0;
    tx_id_next          = '0;
    tx_data_next        = '0;
    deliver_next        = 1'b0;
    data_count_next     = '0;
    data_bytes_next     = '0;
    case (req.action)
      obd_pkg::ACT_SEND: begin
        if (waiting) begin
          status_next = obd_pkg::STAT_BUSY;
        end else begin
          mark_set      = req.with_callback;
          tx_valid_next = 1'b1;
          tx_id_next    = request_id;
          tx_data_next  = {{5{obd_pkg::PAD_BYTE}}, req.pid, req.mode, obd_pkg::REQ_LEN_BYTE};
          if (req.send_ok) begin
            waiting_next        = 1'b1;
            pending_mode_next   = req.mode;
            pending_pid_next    = req.pid;
            pending_marked_next = cb_map[req.pid] || req.with_callback;
            elapsed_next        = '0;
            status_next         = obd_pkg::STAT_SENT;
          end else begin
            status_next = obd_pkg::STAT_SEND_FAIL;
          end
        end
      end
      obd_pkg::ACT_FRAME: begin
        if (chk.match) begin
          deliver_next    = pending_marked;
          data_count_next = chk.count;
          data_bytes_next = req.frame_data[63:24];
          waiting_next    = 1'b0;
          status_next     = obd_pkg::STAT_MATCHED;
        end else begin
          status_next = obd_pkg::STAT_IGNORED;
        end
      end
      obd_pkg::ACT_TICK: begin
        elapsed_next = elapsed_inc;
        if (waiting && (elapsed_inc > {1'b0, timeout_ticks})) begin
          waiting_next = 1'b0;
          status_next  = obd_pkg::STAT_TIMED_OUT;
        end
      end
      default: begin
        status_next = obd_pkg::STAT_IDLE_TICK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_id    <= obd_pkg::REQUEST_ID_RST;
      response_base <= obd_pkg::RESPONSE_BASE_RST;
      timeout_ticks <= obd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        obd_pkg::CFG_REQUEST_ID:    request_id    <= cfg.data[10:0];
        obd_pkg::CFG_RESPONSE_BASE: response_base <= cfg.data[10:0];
        obd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting        <= 1'b0;
      pending_mode   <= '0;
      pending_pid    <= '0;
      pending_marked <= 1'b0;
      elapsed        <= '0;
      cb_map         <= '0;
    end else if (accept) begin
      waiting        <= waiting_next;
      pending_mode   <= pending_mode_next;
      pending_pid    <= pending_pid_next;
      pending_marked <= pending_marked_next;
      elapsed        <= elapsed_next;
      if (mark_set) begin
        cb_map[req.pid] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      tx_valid   <= tx_valid_next;
      tx_id      <= tx_id_next;
      tx_data    <= tx_data_next;
      deliver    <= deliver_next;
      data_count <= data_count_next;
      data_bytes <= data_bytes_next;
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import obd_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  mode;
    logic [7:0]  pid;
    logic        with_callback;
    logic        send_ok;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_data;
    logic        deliver;
    logic [2:0]  data_count;
    logic [39:0] data_bytes;
  } res_item_t;

  class pid_tracker_sb;
    logic [10:0] req_id;
    logic [10:0] rsp_base;
    logic [15:0] tmo;
    bit          waiting;
    logic [7:0]  pend_mode;
    logic [7:0]  pend_pid;
    logic [16:0] elapsed;
    bit          marks [256];
    res_item_t   replies_due [$];
    int errors, taken, checked, matched, delivered, timed_out, busy;

    function new();
      req_id    = REQUEST_ID_RST;
      rsp_base  = RESPONSE_BASE_RST;
      tmo       = TIMEOUT_TICKS_RST;
      waiting   = 1'b0;
      pend_mode = '0;
      pend_pid  = '0;
      elapsed   = '0;
      foreach (marks[i]) marks[i] = 1'b0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_REQUEST_ID:    req_id = val[10:0];
        CFG_RESPONSE_BASE: rsp_base = val[10:0];
        CFG_TIMEOUT_TICKS: tmo = val;
        default: ;
      endcase
    endfunction

    function void apply_request(req_item_t it);
      res_item_t   r;
      logic [7:0]  b0, b1, b2, cnt;
      logic [11:0] id_top;
      bit          hit;
      r = '0;
      r.status = STAT_IDLE_TICK;
      taken++;
      case (it.action)
        ACT_SEND: begin
          if (waiting) begin
            r.status = STAT_BUSY;
          end else begin
            if (it.with_callback) marks[it.pid] = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_id = req_id;
            r.tx_data = {{5{PAD_BYTE}}, it.pid, it.mode, REQ_LEN_BYTE};
            if (it.send_ok) begin
              waiting = 1'b1;
              pend_mode = it.mode;
              pend_pid = it.pid;
              elapsed = '0;
              r.status = STAT_SENT;
            end else begin
              r.status = STAT_SEND_FAIL;
            end
          end
        end
        ACT_FRAME: begin
          b0 = it.frame_data[7:0];
          b1 = it.frame_data[15:8];
          b2 = it.frame_data[23:16];
          id_top = {1'b0, rsp_base} + ID_SPAN;
          hit = waiting && (it.frame_id >= rsp_base) && ({1'b0, it.frame_id} <= id_top) &&
                (it.frame_len >= MIN_RSP_LEN) &&
                ({1'b0, b1} == ({1'b0, pend_mode} + RSP_MODE_OFS)) && (b2 == pend_pid);
          if (hit) begin
            cnt = b0 - RSP_HDR_LEN;
            r.data_count = (cnt > {5'd0, MAX_DATA}) ? MAX_DATA : cnt[2:0];
            r.deliver = marks[pend_pid];
            r.data_bytes = it.frame_data[63:24];
            waiting = 1'b0;
            r.status = STAT_MATCHED;
          end else begin
            r.status = STAT_IGNORED;
          end
        end
        ACT_TICK: begin
          if (elapsed != ELAPSED_MAX) elapsed = elapsed + 17'd1;
          if (waiting && elapsed > {1'b0, tmo}) begin
            waiting = 1'b0;
            r.status = STAT_TIMED_OUT;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void cmp(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_reply(res_item_t got);
      res_item_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply with none outstanding, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      want = replies_due.pop_front();
      checked++;
      cmp("status", want.status, got.status);
      cmp("tx_valid", want.tx_valid, got.tx_valid);
      cmp("tx_id", want.tx_id, got.tx_id);
      cmp("tx_data", want.tx_data, got.tx_data);
      cmp("deliver", want.deliver, got.deliver);
      cmp("data_count", want.data_count, got.data_count);
      cmp("data_bytes", want.data_bytes, got.data_bytes);
      if (want.status == STAT_MATCHED) matched++;
      if (want.deliver) delivered++;
      if (want.status == STAT_TIMED_OUT) timed_out++;
      if (want.status == STAT_BUSY) busy++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   src_pace = 1'b1;
  bit   sink_pace = 1'b1;
  int   n_settings = 1;
  pid_tracker_sb trk = new();

  obd_cfg_if cfg_ch();
  obd_req_if req_ch();
  obd_res_if res_ch();

  obd_pid_request_tracker dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic req_item_t noise_item();
    req_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.mode = 8'($urandom);
    it.pid = 8'($urandom);
    it.with_callback = 1'($urandom);
    it.send_ok = 1'($urandom);
    it.frame_id = 11'($urandom);
    it.frame_len = 4'($urandom);
    it.frame_data = {$urandom, $urandom};
    return it;
  endfunction

  function automatic req_item_t mk_send(logic [7:0] m, logic [7:0] p, logic cb, logic ok);
    req_item_t it;
    it = noise_item();
    it.action = ACT_SEND;
    it.mode = m;
    it.pid = p;
    it.with_callback = cb;
    it.send_ok = ok;
    return it;
  endfunction

  function automatic req_item_t mk_frame(logic [10:0] id, logic [3:0] len, logic [63:0] d);
    req_item_t it;
    it = noise_item();
    it.action = ACT_FRAME;
    it.frame_id = id;
    it.frame_len = len;
    it.frame_data = d;
    return it;
  endfunction

  function automatic req_item_t mk_tick();
    req_item_t it;
    it = noise_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic logic [63:0] rsp_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                            logic [39:0] tail);
    return {tail, b2, b1, b0};
  endfunction

  function automatic req_item_t rand_send();
    logic [7:0] m, p;
    m = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8'hBF));
    p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    return mk_send(m, p, 1'($urandom), $urandom_range(0, 9) != 0);
  endfunction

  // mostly request/answer exchanges, with near misses, ticks and junk mixed in
  function automatic req_item_t pick_item();
    req_item_t   it;
    int          r;
    logic [11:0] id;
    logic [3:0]  len;
    logic [7:0]  b0;
    r = $urandom_range(0, 99);
    if (trk.waiting) begin
      if (r < 60) begin
        id = {1'b0, trk.rsp_base} + 12'($urandom_range(0, 7));
        if (id > 12'd2047) id = {1'b0, trk.rsp_base};
        len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(3, 8));
        b0 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        it = mk_frame(id[10:0], len, rsp_frame(b0, trk.pend_mode + RSP_MODE_OFS[7:0],
                                                trk.pend_pid, {$urandom, 8'($urandom)}));
        if (r >= 45) begin
          case ($urandom_range(0, 4))
            0: it.frame_id = (trk.rsp_base != 11'd0) ? trk.rsp_base - 11'd1 : trk.rsp_base + 11'd8;
            1: it.frame_id = (trk.rsp_base <= 11'd2039) ? trk.rsp_base + 11'd8
                                                         : trk.rsp_base - 11'd1;
            2: it.frame_len = 4'($urandom_range(0, 2));
            3: it.frame_data[15:8] ^= 8'(1 << $urandom_range(0, 7));
            default: it.frame_data[23:16] ^= 8'(1 << $urandom_range(0, 7));
          endcase
        end
      end else if (r < 80) begin
        it = mk_tick();
      end else if (r < 90) begin
        it = rand_send();
      end else begin
        it = noise_item();
      end
    end else begin
      if (r < 60) it = rand_send();
      else if (r < 80) it = mk_tick();
      else it = noise_item();
    end
    return it;
  endfunction

  task automatic push(input req_item_t it);
    int gap;
    gap = src_pace ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= it.action;
    req_ch.mode <= it.mode;
    req_ch.pid <= it.pid;
    req_ch.with_callback <= it.with_callback;
    req_ch.send_ok <= it.send_ok;
    req_ch.frame_id <= it.frame_id;
    req_ch.frame_len <= it.frame_len;
    req_ch.frame_data <= it.frame_data;
    do @(posedge clk); while (!req_ch.ready);
    trk.apply_request(it);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (trk.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    trk.load_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] rid, input logic [15:0] base,
                           input logic [15:0] tmo);
    write_reg(CFG_REQUEST_ID, rid);
    write_reg(CFG_RESPONSE_BASE, base);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int        stall;
    res_item_t got;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_pace ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.status = res_ch.status;
      got.tx_valid = res_ch.tx_valid;
      got.tx_id = res_ch.tx_id;
      got.tx_data = res_ch.tx_data;
      got.deliver = res_ch.deliver;
      got.data_count = res_ch.data_count;
      got.data_bytes = res_ch.data_bytes;
      trk.check_reply(got);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_REQUEST_ID;
    cfg_ch.data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_TICK;
    req_ch.mode <= '0;
    req_ch.pid <= '0;
    req_ch.with_callback <= 1'b0;
    req_ch.send_ok <= 1'b0;
    req_ch.frame_id <= '0;
    req_ch.frame_len <= '0;
    req_ch.frame_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: ids 2015 / 2024..2031, timeout 1000
    push(mk_tick());
    push(mk_frame(11'd2024, 4'd8, rsp_frame(8'h04, 8'h41, 8'h0C, 40'h0)));
    push(mk_send(8'h01, 8'h0C, 1'b1, 1'b0));
    push(mk_send(8'h01, 8'h0C, 1'b0, 1'b1));
    push(mk_send(8'h02, 8'h33, 1'b1, 1'b1));
    push(mk_frame(11'd2023, 4'd8, rsp_frame(8'h04, 8'h41, 8'h0C, 40'h0)));
    push(mk_frame(11'd2032, 4'd8, rsp_frame(8'h04, 8'h41, 8'h0C, 40'h0)));
    push(mk_frame(11'd2024, 4'd2, rsp_frame(8'h04, 8'h41, 8'h0C, 40'h0)));
    push(mk_frame(11'd2027, 4'd8, rsp_frame(8'h04, 8'h40, 8'h0C, 40'h0)));
    push(mk_frame(11'd2027, 4'd8, rsp_frame(8'h04, 8'h41, 8'h0D, 40'h0)));
    push(mk_frame(11'd2031, 4'd3, rsp_frame(8'h02, 8'h41, 8'h0C, 40'hFF_FFFF_FFFF)));
    push(mk_send(8'hBF, 8'h33, 1'b0, 1'b1));
    push(mk_frame(11'd2024, 4'd15, rsp_frame(8'h01, 8'hFF, 8'h33, 40'h12_3456_789A)));
    push(mk_send(8'hC0, 8'h00, 1'b1, 1'b1));
    // mode 0xC0 answers with 0x00 in 8 bits but never in 9
    push(mk_frame(11'd2024, 4'd8, rsp_frame(8'h07, 8'h00, 8'h00, 40'h0)));
    begin : spare_action
      req_item_t it;
      it = noise_item();
      it.action = ACT_SPARE;
      push(it);
    end
    settle();

    configure(16'd0, 16'd0, 16'd1);
    push(mk_tick());
    push(mk_send(8'h00, 8'hFF, 1'b1, 1'b1));
    push(mk_tick());
    push(mk_tick());
    push(mk_send(8'h00, 8'hFF, 1'b0, 1'b1));
    push(mk_frame(11'd7, 4'd8, rsp_frame(8'hFF, 8'h40, 8'hFF, 40'h0)));
    settle();

    configure(16'hFFFF, 16'd2040, 16'd0);
    push(mk_send(8'hFF, 8'hFF, 1'b0, 1'b1));
    push(mk_tick());
    push(mk_send(8'h01, 8'h0C, 1'b0, 1'b1));
    push(mk_frame(11'd2047, 4'd8, rsp_frame(8'h06, 8'h41, 8'h0C, 40'hAA_5555_AA00)));
    push(mk_send(8'h3E, 8'h80, 1'b0, 1'b1));
    push(mk_tick());

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          src_pace = 1'b1;
          sink_pace = 1'b1;
          configure(16'd0, 16'd2047, 16'd1);
        end
        1: begin
          src_pace = 1'b0;
          sink_pace = 1'b0;
          configure(16'd2047, 16'd0, 16'd0);
        end
        2: begin
          src_pace = 1'b0;
          sink_pace = 1'b1;
          configure(16'($urandom), 16'd2040, 16'd3);
        end
        3: begin
          src_pace = 1'b1;
          sink_pace = 1'b1;
          write_reg(CFG_SPARE, 16'($urandom));
          configure(16'($urandom), 16'($urandom), 16'hFFFF);
        end
        4: begin
          src_pace = 1'b1;
          sink_pace = 1'b0;
          configure(16'($urandom), 16'($urandom_range(0, 2047)), 16'($urandom_range(1, 10)));
        end
        default: begin
          src_pace = 1'b1;
          sink_pace = 1'b1;
          configure(REQUEST_ID_RST, RESPONSE_BASE_RST, TIMEOUT_TICKS_RST);
        end
      endcase
      repeat (70) push(pick_item());
    end
    settle();
    repeat (4) @(posedge clk);

    $display("Ran %0d items under %0d register settings; %0d replies checked.",
             trk.taken, n_settings, trk.checked);
    $display("Answers matched %0d (%0d delivered), requests timed out %0d, busy refusals %0d.",
             trk.matched, trk.delivered, trk.timed_out, trk.busy);
    if (trk.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/obd_pkg.sv
hw/rtl/obd_cfg_if.sv
hw/rtl/obd_req_if.sv
hw/rtl/obd_res_if.sv
hw/rtl/obd_rsp_check.sv
hw/rtl/obd_pid_request_tracker.sv
sim/tb_top.sv
